@@ hdl/lphi_pkg.sv @@
`default_nettype none
package lphi_pkg;

	localparam int SLOTS  = 64;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	localparam int SIZE_W = 7;
	localparam int COLL_W = 32;
	localparam int INS_W  = 32;
	localparam int FULL_W = 16;

	localparam logic [KEY_W-1:0] KEY_EMPTY = {KEY_W{1'b1}};

	// request modes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;
	localparam logic [1:0] MODE_ZERO   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_RESERVED = 2'd2;
	localparam logic [1:0] ST_RANGE    = 2'd3;

	typedef struct packed {
		logic       load;
		logic       start;
		logic       place;
		logic       collide;
		logic       full_evt;
		logic       set_status;
		logic [1:0] status;
		logic       read_ok;
		logic       clear_tab;
		logic       zero_cnt;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       home_oor;
		logic       key_res;
		logic       ridx_oor;
		logic       slot_empty;
		logic       probe_last;
		logic       out_free;
	} stat_t;

endpackage
`default_nettype wire

@@ hdl/lphi_ctrl.sv @@
`default_nettype none
module lphi_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	input  lphi_pkg::stat_t st,
	output lphi_pkg::cmd_t  cmd,
	output logic           busy
);
	import lphi_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_PROBE  = 3'd2;
	localparam logic [2:0] S_FINISH = 3'd3;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				case (st.mode)
					MODE_INSERT: begin
						if (st.home_oor) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_RANGE;
						end else if (st.key_res) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_RESERVED;
						end else begin
							cmd.start = 1'b1;
							state_d   = S_PROBE;
						end
					end
					MODE_READ: begin
						if (st.ridx_oor) begin
							cmd.set_status = 1'b1;
							cmd.status     = ST_RANGE;
						end else begin
							cmd.read_ok = 1'b1;
						end
					end
					MODE_CLEAR: cmd.clear_tab = 1'b1;
					default:    cmd.zero_cnt  = 1'b1;
				endcase
			end
			S_PROBE: begin
				if (st.slot_empty) begin
					cmd.place = 1'b1;
					state_d   = S_FINISH;
				end else begin
					cmd.collide = 1'b1;
					if (st.probe_last) begin
						// every slot within the size stepped over once: give up
						cmd.full_evt   = 1'b1;
						cmd.set_status = 1'b1;
						cmd.status     = ST_FULL;
						state_d        = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/lphi_dp.sv @@
`default_nettype none
module lphi_dp (
	input  wire                           clk,
	input  wire                           arst_n,
	input  lphi_pkg::cmd_t                cmd,
	output lphi_pkg::stat_t               st,
	input  wire [1:0]                     mode,
	input  wire [lphi_pkg::KEY_W-1:0]     key,
	input  wire [lphi_pkg::VAL_W-1:0]     value,
	input  wire [lphi_pkg::SLOT_W-1:0]    home_slot,
	input  wire [lphi_pkg::SLOT_W-1:0]    read_index,
	input  wire                           cfg_we,
	input  wire [lphi_pkg::SIZE_W-1:0]    cfg_size,
	input  wire                           out_stall,
	output logic                          out_valid,
	output logic [1:0]                    status,
	output logic [lphi_pkg::SLOT_W-1:0]   placed_slot,
	output logic [lphi_pkg::KEY_W-1:0]    slot_key,
	output logic [lphi_pkg::VAL_W-1:0]    slot_value,
	output logic                          slot_full,
	output logic [lphi_pkg::CNT_W-1:0]    in_use_count,
	output logic [lphi_pkg::COLL_W-1:0]   probe_collisions,
	output logic [lphi_pkg::INS_W-1:0]    insert_count,
	output logic [lphi_pkg::FULL_W-1:0]   full_events
);
	import lphi_pkg::*;

	// request registers
	logic [1:0]        mode_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [SLOT_W-1:0] home_q;
	logic [SLOT_W-1:0] ridx_q;

	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  eff_size;

	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  probes_q;
	logic [SLOT_W-1:0] slot_nxt;

	logic [SLOTS-1:0]  used_q;

	logic [KEY_W-1:0]  key_mem [SLOTS];
	logic [VAL_W-1:0]  val_mem [SLOTS];
	logic [KEY_W-1:0]  rd_key_q;
	logic [VAL_W-1:0]  rd_val_q;
	logic [SLOT_W-1:0] rd_addr;

	logic [CNT_W-1:0]  occ_q;
	logic [COLL_W-1:0] coll_q;
	logic [INS_W-1:0]  ins_q;
	logic [FULL_W-1:0] full_q;

	logic [1:0]        res_status_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_read_q;
	logic              res_used;

	logic              out_valid_q;

	// clamp table size into 1..SLOTS
	always_comb begin
		if (size_q == '0) begin
			eff_size = CNT_W'(1);
		end else if (CNT_W'(size_q) > CNT_W'(SLOTS)) begin
			eff_size = CNT_W'(SLOTS);
		end else begin
			eff_size = CNT_W'(size_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(SLOTS);
		end else if (cfg_we) begin
			size_q <= cfg_size;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			key_q  <= key;
			val_q  <= value;
			home_q <= home_slot;
			ridx_q <= read_index;
		end
	end

	always_comb begin
		if (CNT_W'(slot_q) + CNT_W'(1) >= eff_size) begin
			slot_nxt = '0;
		end else begin
			slot_nxt = slot_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			slot_q   <= home_q;
			probes_q <= '0;
		end else if (cmd.collide) begin
			slot_q   <= slot_nxt;
			probes_q <= probes_q + CNT_W'(1);
		end
	end

	// occupancy bits stand in for the empty-key reset of the key store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.clear_tab) begin
			used_q <= '0;
		end else if (cmd.place) begin
			used_q[slot_q] <= 1'b1;
		end
	end

	assign rd_addr = cmd.load ? read_index : ridx_q;

	always_ff @(posedge clk) begin
		if (cmd.place) begin
			key_mem[slot_q] <= key_q;
			val_mem[slot_q] <= val_q;
		end
		rd_key_q <= key_mem[rd_addr];
		rd_val_q <= val_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			coll_q <= '0;
			ins_q  <= '0;
			full_q <= '0;
		end else begin
			if (cmd.clear_tab) begin
				occ_q <= '0;
			end else if (cmd.place) begin
				occ_q <= occ_q + CNT_W'(1);
			end
			if (cmd.zero_cnt) begin
				coll_q <= '0;
				ins_q  <= '0;
				full_q <= '0;
			end else begin
				if (cmd.collide) begin
					coll_q <= coll_q + COLL_W'(1);
				end
				if (cmd.place) begin
					ins_q <= ins_q + INS_W'(1);
				end
				if (cmd.full_evt && (full_q != {FULL_W{1'b1}})) begin
					full_q <= full_q + FULL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
			res_read_q   <= 1'b0;
		end else if (cmd.load) begin
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
			res_read_q   <= 1'b0;
		end else begin
			if (cmd.set_status) begin
				res_status_q <= cmd.status;
			end
			if (cmd.place) begin
				res_slot_q <= slot_q;
			end
			if (cmd.read_ok) begin
				res_slot_q <= ridx_q;
				res_read_q <= 1'b1;
			end
		end
	end

	assign res_used = used_q[res_slot_q];

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status           <= res_status_q;
			placed_slot      <= res_slot_q;
			slot_key         <= res_read_q ? (res_used ? rd_key_q : KEY_EMPTY) : '0;
			slot_value       <= res_read_q ? rd_val_q : '0;
			slot_full        <= res_read_q & res_used;
			in_use_count     <= occ_q;
			probe_collisions <= coll_q;
			insert_count     <= ins_q;
			full_events      <= full_q;
		end
	end

	assign out_valid = out_valid_q;

	assign st.mode       = mode_q;
	assign st.home_oor   = CNT_W'(home_q) >= eff_size;
	assign st.key_res    = key_q == KEY_EMPTY;
	assign st.ridx_oor   = CNT_W'(ridx_q) >= eff_size;
	assign st.slot_empty = !used_q[slot_q];
	assign st.probe_last = (probes_q + CNT_W'(1)) == eff_size;
	assign st.out_free   = !out_valid_q || !out_stall;

endmodule
`default_nettype wire

@@ hdl/linear_probe_hash_insert.sv @@
// Channel   Direction  Handshake            Carries
// in        request    in_valid / in_stall  mode, key, value, home_slot, read_index
// out       result     out_valid/out_stall  status .. full_events
// cfg       write      cfg_valid/cfg_ready  table_size
//
// Read, clear, zero, refused inserts: decode, then finish loads the result register.
// Inserts probe in between, over occupied slots until a free one; a full table gives up.
// The probe walks the occupancy bits one slot per cycle; that loop sets the rate.
// After reset the table is empty at once; clear resets all occupancy bits together.
// in_stall is high while a request is in flight; a held result only stalls the finish.
`default_nettype none
module linear_probe_hash_insert (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire [1:0]                     mode,
	input  wire [lphi_pkg::KEY_W-1:0]     key,
	input  wire [lphi_pkg::VAL_W-1:0]     value,
	input  wire [lphi_pkg::SLOT_W-1:0]    home_slot,
	input  wire [lphi_pkg::SLOT_W-1:0]    read_index,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic [1:0]                    status,
	output logic [lphi_pkg::SLOT_W-1:0]   placed_slot,
	output logic [lphi_pkg::KEY_W-1:0]    slot_key,
	output logic [lphi_pkg::VAL_W-1:0]    slot_value,
	output logic                          slot_full,
	output logic [lphi_pkg::CNT_W-1:0]    in_use_count,
	output logic [lphi_pkg::COLL_W-1:0]   probe_collisions,
	output logic [lphi_pkg::INS_W-1:0]    insert_count,
	output logic [lphi_pkg::FULL_W-1:0]   full_events,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [lphi_pkg::SIZE_W-1:0]    table_size
);
	import lphi_pkg::*;

	cmd_t  cmd;
	stat_t st;
	logic  busy;

	assign cfg_ready = 1'b1;
	assign in_stall  = busy;

	lphi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.cmd      (cmd),
		.busy     (busy)
	);

	lphi_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.st               (st),
		.mode             (mode),
		.key              (key),
		.value            (value),
		.home_slot        (home_slot),
		.read_index       (read_index),
		.cfg_we           (cfg_valid & cfg_ready),
		.cfg_size         (table_size),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.status           (status),
		.placed_slot      (placed_slot),
		.slot_key         (slot_key),
		.slot_value       (slot_value),
		.slot_full        (slot_full),
		.in_use_count     (in_use_count),
		.probe_collisions (probe_collisions),
		.insert_count     (insert_count),
		.full_events      (full_events)
	);

endmodule
`default_nettype wire

@@ hdl/lphi_chk.sv @@
`default_nettype none
module lphi_chk (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           in_valid,
	input wire                           in_stall,
	input wire                           out_valid,
	input wire                           out_stall,
	input wire [1:0]                     status,
	input wire [lphi_pkg::SLOT_W-1:0]    placed_slot,
	input wire [lphi_pkg::KEY_W-1:0]     slot_key,
	input wire [lphi_pkg::VAL_W-1:0]     slot_value,
	input wire                           slot_full,
	input wire [lphi_pkg::CNT_W-1:0]     in_use_count
);
	import lphi_pkg::*;

	// a request just taken keeps the input side closed
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after request accepted");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status) && $stable(placed_slot)))
		else $error("stalled result changed");

	a_full_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && slot_full) |-> (status == ST_OK))
		else $error("occupied slot reported with error status");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_OK) |->
		(placed_slot == '0 && slot_key == '0 && slot_value == '0 && !slot_full))
		else $error("refused request carries slot data");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (in_use_count <= CNT_W'(SLOTS)))
		else $error("occupancy above table depth");

endmodule

bind linear_probe_hash_insert lphi_chk u_lphi_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.placed_slot  (placed_slot),
	.slot_key     (slot_key),
	.slot_value   (slot_value),
	.slot_full    (slot_full),
	.in_use_count (in_use_count)
);
`default_nettype wire

@@ tb/linear_probe_hash_insert_tb.sv @@
`timescale 1ns / 100ps
module linear_probe_hash_insert_tb;
	import lphi_pkg::*;

	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 150;

	typedef struct packed {
		logic [1:0]        mode;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
		logic [SLOT_W-1:0] home_slot;
		logic [SLOT_W-1:0] read_index;
	} hash_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] placed_slot;
		logic [KEY_W-1:0]  slot_key;
		logic [VAL_W-1:0]  slot_value;
		logic              slot_full;
		logic [CNT_W-1:0]  in_use_count;
		logic [COLL_W-1:0] probe_collisions;
		logic [INS_W-1:0]  insert_count;
		logic [FULL_W-1:0] full_events;
	} hash_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic [1:0]        mode       = MODE_INSERT;
	logic [KEY_W-1:0]  key        = '0;
	logic [VAL_W-1:0]  value      = '0;
	logic [SLOT_W-1:0] home_slot  = '0;
	logic [SLOT_W-1:0] read_index = '0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic [1:0]        status;
	logic [SLOT_W-1:0] placed_slot;
	logic [KEY_W-1:0]  slot_key;
	logic [VAL_W-1:0]  slot_value;
	logic              slot_full;
	logic [CNT_W-1:0]  in_use_count;
	logic [COLL_W-1:0] probe_collisions;
	logic [INS_W-1:0]  insert_count;
	logic [FULL_W-1:0] full_events;
	logic              cfg_valid  = 1'b0;
	logic              cfg_ready;
	logic [SIZE_W-1:0] table_size = '0;

	linear_probe_hash_insert dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.mode             (mode),
		.key              (key),
		.value            (value),
		.home_slot        (home_slot),
		.read_index       (read_index),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.placed_slot      (placed_slot),
		.slot_key         (slot_key),
		.slot_value       (slot_value),
		.slot_full        (slot_full),
		.in_use_count     (in_use_count),
		.probe_collisions (probe_collisions),
		.insert_count     (insert_count),
		.full_events      (full_events),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.table_size       (table_size)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the table and its counters
	logic [KEY_W-1:0]  slot_keys    [SLOTS];
	logic [VAL_W-1:0]  slot_vals    [SLOTS];
	bit                slot_written [SLOTS];
	logic [CNT_W-1:0]  occupied;
	logic [COLL_W-1:0] probe_total;
	logic [INS_W-1:0]  insert_total;
	logic [FULL_W-1:0] full_total;
	logic [SIZE_W-1:0] size_cfg;

	hash_req_t    pending_reqs [$];
	hash_result_t expected_results [$];
	hash_req_t    offered;
	hash_result_t got, want;
	int           reqs_made, reqs_taken, results_seen, mismatches;
	int           in_gap, out_gap, hold_left;
	bit           hold_done, idle_on;

	function automatic int eff_size();
		if (size_cfg == 0) return 1;
		if (size_cfg > SLOTS) return SLOTS;
		return size_cfg;
	endfunction

	function automatic hash_result_t table_outcome(hash_req_t r);
		hash_result_t res;
		int           eff, slot, probes;
		bit           found;
		eff = eff_size();
		res = '0;
		case (r.mode)
			MODE_INSERT: begin
				if (r.home_slot >= eff) begin
					res.status = ST_RANGE;
				end else if (r.key == KEY_EMPTY) begin
					res.status = ST_RESERVED;
				end else begin
					slot   = r.home_slot;
					probes = 0;
					found  = 1'b0;
					// each slot within the size is visited at most once
					while (!found && probes < eff) begin
						if (slot_keys[slot] == KEY_EMPTY) begin
							found = 1'b1;
						end else begin
							probe_total++;
							probes++;
							slot = (slot + 1 >= eff) ? 0 : slot + 1;
						end
					end
					if (found) begin
						slot_keys[slot]    = r.key;
						slot_vals[slot]    = r.value;
						slot_written[slot] = 1'b1;
						occupied++;
						insert_total++;
						res.placed_slot = SLOT_W'(slot);
					end else begin
						res.status = ST_FULL;
						if (full_total != '1) full_total++;
					end
				end
			end
			MODE_READ: begin
				if (r.read_index >= eff) begin
					res.status = ST_RANGE;
				end else begin
					res.placed_slot = r.read_index;
					res.slot_key    = slot_keys[r.read_index];
					res.slot_value  = slot_vals[r.read_index];
					res.slot_full   = slot_keys[r.read_index] != KEY_EMPTY;
				end
			end
			MODE_CLEAR: begin
				// whole table, not only the slots within the size
				for (slot = 0; slot < SLOTS; slot++) slot_keys[slot] = KEY_EMPTY;
				occupied = '0;
			end
			default: begin
				probe_total  = '0;
				insert_total = '0;
				full_total   = '0;
			end
		endcase
		res.in_use_count     = occupied;
		res.probe_collisions = probe_total;
		res.insert_count     = insert_total;
		res.full_events      = full_total;
		return res;
	endfunction

	// never reads the value of a slot that has not been written
	function automatic hash_req_t random_request(int clear_pct);
		hash_req_t r;
		int        eff, roll, i;
		int        ok_slots [$];
		eff          = eff_size();
		roll         = $urandom_range(0, 99);
		r.key        = $urandom();
		r.value      = $urandom();
		r.home_slot  = ($urandom_range(0, 3) == 0) ? SLOT_W'($urandom_range(0, 63))
		                                           : SLOT_W'($urandom_range(0, eff - 1));
		r.read_index = SLOT_W'($urandom_range(0, 63));
		case ($urandom_range(0, 15))
			0: r.key = KEY_EMPTY;
			1: r.key = '0;
			2: r.key = KEY_EMPTY - 1;
			default: ;
		endcase
		if (roll < clear_pct) r.mode = MODE_CLEAR;
		else if (roll < clear_pct + 4) r.mode = MODE_ZERO;
		else if (roll < clear_pct + 34) r.mode = MODE_READ;
		else r.mode = MODE_INSERT;
		if (r.mode == MODE_READ) begin
			for (i = 0; i < eff; i++) if (slot_written[i]) ok_slots.push_back(i);
			if (ok_slots.size() != 0 && $urandom_range(0, 4) != 0) begin
				r.read_index = SLOT_W'(ok_slots[$urandom_range(0, ok_slots.size() - 1)]);
			end else if (r.read_index < eff && !slot_written[r.read_index]) begin
				if (eff < SLOTS) r.read_index = SLOT_W'($urandom_range(eff, 63));
				else if (ok_slots.size() != 0)
					r.read_index = SLOT_W'(ok_slots[$urandom_range(0, ok_slots.size() - 1)]);
				else r.mode = MODE_INSERT;
			end
		end
		return r;
	endfunction

	task automatic send_req(hash_req_t r);
		while (pending_reqs.size() > 1) @(posedge clk);
		pending_reqs.push_back(r);
		reqs_made++;
	endtask

	task automatic queue_req(logic [1:0] m, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
		int h, int ri);
		hash_req_t r;
		r.mode       = m;
		r.key        = k;
		r.value      = v;
		r.home_slot  = SLOT_W'(h);
		r.read_index = SLOT_W'(ri);
		send_req(r);
	endtask

	task automatic wait_drained();
		while (reqs_taken != reqs_made || expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_size(logic [SIZE_W-1:0] sz);
		wait_drained();
		@(posedge clk);
		cfg_valid  <= 1'b1;
		table_size <= sz;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_cfg = sz;
	endtask

	task automatic run_phase(logic [SIZE_W-1:0] sz, int count, int clear_pct, bit idle);
		int n;
		write_size(sz);
		idle_on = idle;
		for (n = 0; n < count; n++) send_req(random_request(clear_pct));
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(table_outcome(offered));
				reqs_taken++;
				in_gap = idle_on ? $urandom_range(0, 4) : 0;
			end
			if (!in_valid || !in_stall) begin
				if (in_gap == 0 && pending_reqs.size() != 0) begin
					offered = pending_reqs.pop_front();
					in_valid   <= 1'b1;
					mode       <= offered.mode;
					key        <= offered.key;
					value      <= offered.value;
					home_slot  <= offered.home_slot;
					read_index <= offered.read_index;
				end else begin
					if (in_gap > 0) in_gap--;
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got = {status, placed_slot, slot_key, slot_value, slot_full, in_use_count,
					probe_collisions, insert_count, full_events};
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status=%0d slot=%0d", status, placed_slot);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d mismatch", results_seen);
							$display("  exp st=%0d slot=%0d key=%h val=%h full=%b",
								want.status, want.placed_slot, want.slot_key,
								want.slot_value, want.slot_full);
							$display("      used=%0d coll=%0d ins=%0d fev=%0d",
								want.in_use_count, want.probe_collisions,
								want.insert_count, want.full_events);
							$display("  got st=%0d slot=%0d key=%h val=%h full=%b",
								got.status, got.placed_slot, got.slot_key,
								got.slot_value, got.slot_full);
							$display("      used=%0d coll=%0d ins=%0d fev=%0d",
								got.in_use_count, got.probe_collisions,
								got.insert_count, got.full_events);
						end
					end
				end
				out_gap = idle_on ? $urandom_range(0, 4) : 0;
				// one long back-pressure stretch while requests keep coming
				if (!hold_done && results_seen >= 150 && pending_reqs.size() != 0) begin
					hold_left = HOLD_CYCLES;
					hold_done = 1'b1;
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		int i;
		for (i = 0; i < SLOTS; i++) begin
			slot_keys[i]    = KEY_EMPTY;
			slot_vals[i]    = '0;
			slot_written[i] = 1'b0;
		end
		occupied     = '0;
		probe_total  = '0;
		insert_total = '0;
		full_total   = '0;
		size_cfg     = 7'd64;
		idle_on      = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// full size after reset: edge slots, wrap, reserved key, read back
		queue_req(MODE_INSERT, '0, '0, 0, 0);
		queue_req(MODE_INSERT, KEY_EMPTY - 1, '1, 63, 63);
		queue_req(MODE_INSERT, 32'h1234_5678, 32'hA5A5_A5A5, 63, 0);
		queue_req(MODE_INSERT, KEY_EMPTY, 32'h0000_0001, 10, 0);
		queue_req(MODE_READ, '1, '1, 63, 0);
		queue_req(MODE_READ, '0, '0, 0, 63);
		queue_req(MODE_READ, '0, '0, 0, 1);
		queue_req(MODE_INSERT, 32'd7, 32'hFFFF_0000, 0, 0);
		queue_req(MODE_ZERO, '0, '0, 0, 0);
		queue_req(MODE_INSERT, 32'd9, 32'h5A5A_5A5A, 2, 0);
		queue_req(MODE_CLEAR, '1, '1, 63, 63);
		queue_req(MODE_READ, '0, '0, 0, 63);
		queue_req(MODE_INSERT, 32'd1, 32'd1, 63, 0);

		// single slot: full table, home and read index out of range
		write_size(7'd1);
		queue_req(MODE_INSERT, 32'd2, 32'd2, 0, 0);
		queue_req(MODE_INSERT, 32'd3, 32'd3, 0, 0);
		queue_req(MODE_INSERT, 32'd4, 32'd4, 5, 0);
		queue_req(MODE_READ, '0, '0, 0, 3);
		queue_req(MODE_READ, '0, '0, 0, 0);
		queue_req(MODE_INSERT, KEY_EMPTY, '0, 0, 0);
		queue_req(MODE_INSERT, KEY_EMPTY, '0, 1, 0);

		// size zero clamps to one
		write_size(7'd0);
		queue_req(MODE_INSERT, 32'd5, 32'd5, 0, 0);
		queue_req(MODE_READ, '0, '0, 0, 0);

		run_phase(7'd127, 50, 10, 1'b1);
		run_phase(7'd1, 30, 8, 1'b0);
		run_phase(7'd64, 60, 0, 1'b1);
		run_phase(7'd8, 40, 6, 1'b1);
		run_phase(7'd3, 30, 8, 1'b0);
		run_phase(7'd64, 60, 0, 1'b1);
		run_phase(7'd16, 45, 5, 1'b1);
		run_phase(7'd2, 30, 8, 1'b0);
		run_phase(7'd40, 50, 6, 1'b1);
		run_phase(SIZE_W'($urandom_range(0, 127)), 55, 5, 1'b1);

		wait_drained();
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
